// ===== sv/cbse_pkg.sv =====
// Shared types and constants for the cubic B-spline evaluator.
// Used by cubic_bspline_evaluator; depends on nothing else.
package cbse_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_POS  = 2'd1,
        MODE_VEL  = 2'd2,
        MODE_ACC  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_INDEX  = 2'd1,
        ST_FEW_POINTS = 2'd2,
        ST_SATURATED  = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_POINT_COUNT = 1'b0,
        REG_INV_KNOT    = 1'b1
    } cfg_reg_t;

    // Control that travels down the pipeline with each word.
    typedef struct packed {
        logic       valid;
        mode_t      mode;
        status_t    status;
        logic       query;
        logic [7:0] seg;
    } ctrl_t;

    localparam int               MIN_POINTS = 4;
    localparam logic [23:0]      INV_RESET  = 24'h01_0000;
    localparam logic signed [55:0] ONE48    = 56'sh1_0000_0000_0000;
    localparam logic [54:0]      WHALF      = 55'h300_0000;
    localparam logic [31:0]      RECIP3     = 32'hAAAA_AAAB;
    localparam logic [16:0]      D_END      = 17'h1_0000;

endpackage

// ===== sv/cbse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; instantiated by cubic_bspline_evaluator.
module cbse_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cubic_bspline_evaluator.sv =====
// Top level of the uniform cubic B-spline evaluator (three dimensions, Q16.16).
// Depends on cbse_pkg and cbse_ram.
//
// Usage: the s_ channel takes one word per item. A load word (mode 0) stores a
// control point at s_point_index; a query word (mode 1, 2, 3) returns position,
// velocity or acceleration at s_param_u. Every word yields exactly one result
// word on the m_ channel, in order; loads answer with zeros and a status.
// The configuration port (cfg_wr_en, cfg_index, cfg_wdata) sets the point count
// and the reciprocal knot interval; write it only while the block is idle (the block does not enforce this).
// The pipeline has 15 register stages, from input capture to the result
// register. It accepts one word every cycle unless the receiver stalls; the point store is
// split into four banks by index modulo four, so the four neighboring points
// of a query are read from the four banks together. Loads write the
// banks at the same stage where queries read them, so store accesses stay in
// item order without forwarding.
// If the receiver stalls (m_valid high, m_ready low), the whole pipeline holds
// and s_ready drops in the same cycle; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline, sets the point count
// to zero and the reciprocal interval to 1.0. The store is not cleared: a
// point must be loaded before a query reads it.
module cubic_bspline_evaluator #(
    parameter int MAX_POINTS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [23:0]        cfg_wdata,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [7:0]         s_point_index,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic [31:0]        s_param_u,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic [7:0]         m_segment,
    output logic [1:0]         m_status
);

    localparam int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int BANK_DEPTH = (MAX_POINTS + 3) / 4;
    localparam int RW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int NW         = $clog2(MAX_POINTS + 1);
    localparam int CW         = (NW > 9) ? NW : 9;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_POINTS);
    localparam int NST        = 15;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [8:0]  pc_reg;
    logic [23:0] inv_reg;
    logic [47:0] inv_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= '0;
            inv_reg <= cbse_pkg::INV_RESET;
        end else if (cfg_wr_en) begin
            case (cbse_pkg::cfg_reg_t'(cfg_index))
                cbse_pkg::REG_POINT_COUNT: begin
                    pc_reg <= cfg_wdata[8:0];
                end
                cbse_pkg::REG_INV_KNOT: begin
                    inv_reg <= cfg_wdata;
                end
                default: begin
                    pc_reg <= pc_reg;
                end
            endcase
        end
    end

    // The square is refreshed every cycle; configuration must be changed only while idle
    // (the block does not enforce this), long before a query reaches the scaling stage.
    always_ff @(posedge aclk) begin
        inv_sq_reg <= inv_reg * inv_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together.
    // ------------------------------------------------------------------
    logic adv;
    cbse_pkg::ctrl_t ctrl_reg [1:NST];
    cbse_pkg::ctrl_t ctrl3_next;

    assign adv     = !ctrl_reg[NST].valid || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= NST; i++) begin
                ctrl_reg[i] <= '0;
            end
        end else if (adv) begin
            ctrl_reg[1].valid  <= s_valid;
            ctrl_reg[1].mode   <= cbse_pkg::mode_t'(s_mode);
            ctrl_reg[1].status <= cbse_pkg::ST_OK;
            ctrl_reg[1].query  <= 1'b0;
            ctrl_reg[1].seg    <= '0;
            ctrl_reg[2]        <= ctrl_reg[1];
            ctrl_reg[3]        <= ctrl3_next;
            for (int i = 4; i <= NST; i++) begin
                ctrl_reg[i] <= ctrl_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input capture. Stage 2: t = u * inv.
    // ------------------------------------------------------------------
    logic [7:0]         idx1_reg, idx2_reg;
    logic [95:0]        pt1_reg, pt2_reg;
    logic [31:0]        u1_reg;
    logic [55:0]        t2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx1_reg <= s_point_index;
            pt1_reg  <= {s_point_x, s_point_y, s_point_z};
            u1_reg   <= s_param_u;
            idx2_reg <= idx1_reg;
            pt2_reg  <= pt1_reg;
            t2_reg   <= u1_reg * inv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: segment clamp, split of t, store access.
    // ------------------------------------------------------------------
    logic [CW-1:0] n_pc, n_eff, n_last;
    logic          few;
    logic [23:0]   kr, last24, k24;
    logic          over;
    logic [AW-1:0] k_c;
    logic [16:0]   d_c;
    logic          idx_ok;

    always_comb begin
        n_pc   = CW'(pc_reg);
        n_eff  = (n_pc > MAX_N) ? MAX_N : n_pc;
        few    = n_eff < CW'(cbse_pkg::MIN_POINTS);
        n_last = n_eff - CW'(cbse_pkg::MIN_POINTS);
        last24 = 24'(n_last);
        kr     = t2_reg[55:32];
        over   = kr > last24;
        k24    = over ? last24 : kr;
        k_c    = AW'(k24);
        d_c    = over ? cbse_pkg::D_END : {1'b0, t2_reg[31:16]};
        idx_ok = 32'(idx2_reg) < MAX_POINTS;

        ctrl3_next = ctrl_reg[2];
        if (ctrl_reg[2].mode == cbse_pkg::MODE_LOAD) begin
            ctrl3_next.status = idx_ok ? cbse_pkg::ST_OK : cbse_pkg::ST_BAD_INDEX;
        end else if (few) begin
            ctrl3_next.status = cbse_pkg::ST_FEW_POINTS;
        end else begin
            ctrl3_next.query = 1'b1;
            ctrl3_next.seg   = 8'(k24);
        end
    end

    // Four banks, bank b holds points whose index is b modulo four.
    logic [RW-1:0] raddr [4];
    logic [95:0]   rdata [4];
    logic [RW-1:0] waddr;
    logic [AW:0]   ridx  [4];
    logic [1:0]    roff  [4];

    assign waddr = RW'(idx2_reg >> 2);

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            roff[b]  = 2'(b) - k_c[1:0];
            ridx[b]  = (AW+1)'(k_c) + (AW+1)'(roff[b]);
            raddr[b] = RW'(ridx[b] >> 2);
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic we_b;
        assign we_b = adv && ctrl_reg[2].valid && idx_ok
                      && (ctrl_reg[2].mode == cbse_pkg::MODE_LOAD)
                      && (idx2_reg[1:0] == 2'(b));
        cbse_ram #(
            .WIDTH (96),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (aclk),
            .we    (we_b),
            .waddr (waddr),
            .wdata (pt2_reg),
            .re    (adv),
            .raddr (raddr[b]),
            .rdata (rdata[b])
        );
    end

    logic [AW-1:0] k3_reg;
    logic [16:0]   d3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            k3_reg <= k_c;
            d3_reg <= d_c;
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 and 5: gather points in order, powers of d.
    // ------------------------------------------------------------------
    logic signed [31:0] pts_reg [4:8][4][3];
    logic [16:0]        d4_reg, d5_reg;
    logic [33:0]        dd4_reg, dd5_reg;
    logic [49:0]        ddd5_reg;
    logic [1:0]         gsel [4];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            gsel[j] = k3_reg[1:0] + 2'(j);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                pts_reg[4][j][0] <= rdata[gsel[j]][95:64];
                pts_reg[4][j][1] <= rdata[gsel[j]][63:32];
                pts_reg[4][j][2] <= rdata[gsel[j]][31:0];
            end
            for (int s = 5; s <= 8; s++) begin
                pts_reg[s] <= pts_reg[s-1];
            end
            d4_reg   <= d3_reg;
            dd4_reg  <= d3_reg * d3_reg;
            d5_reg   <= d4_reg;
            dd5_reg  <= dd4_reg;
            ddd5_reg <= 50'(dd4_reg) * 50'(d4_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: six times the basis weights in Q.48.
    // ------------------------------------------------------------------
    logic signed [55:0] dp1, dp2, dp3;
    logic signed [55:0] a_c   [4];
    logic signed [55:0] a6_reg [4];

    always_comb begin
        dp1 = signed'({7'b0, d5_reg, 32'b0});
        dp2 = signed'({7'b0, dd5_reg[32:0], 16'b0});
        dp3 = signed'({6'b0, ddd5_reg});
        case (ctrl_reg[5].mode)
            cbse_pkg::MODE_VEL: begin
                a_c[0] = -3 * cbse_pkg::ONE48 + 6 * dp1 - 3 * dp2;
                a_c[1] = 9 * dp2 - 12 * dp1;
                a_c[2] = -9 * dp2 + 6 * dp1 + 3 * cbse_pkg::ONE48;
                a_c[3] = 3 * dp2;
            end
            cbse_pkg::MODE_ACC: begin
                a_c[0] = 6 * cbse_pkg::ONE48 - 6 * dp1;
                a_c[1] = 18 * dp1 - 12 * cbse_pkg::ONE48;
                a_c[2] = -18 * dp1 + 6 * cbse_pkg::ONE48;
                a_c[3] = 6 * dp1;
            end
            default: begin
                a_c[0] = cbse_pkg::ONE48 - 3 * dp1 + 3 * dp2 - dp3;
                a_c[1] = 3 * dp3 - 6 * dp2 + 4 * cbse_pkg::ONE48;
                a_c[2] = -3 * dp3 + 3 * dp2 + 3 * dp1 + cbse_pkg::ONE48;
                a_c[3] = dp3;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stages 7 and 8: divide by 6 * 2^24 with rounding, half away from zero.
    // The shift by 25 takes out 2^24 and the factor 2; the rest is a
    // multiplication by the reciprocal of 3.
    // ------------------------------------------------------------------
    logic [29:0]        y7_reg   [4];
    logic               neg7_reg [4];
    logic signed [27:0] w8_reg   [4];
    logic [55:0]        amag     [4];
    logic [54:0]        asum     [4];
    logic [61:0]        qprod    [4];
    logic [27:0]        qv       [4];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            amag[j]  = a6_reg[j][55] ? 56'(-a6_reg[j]) : 56'(a6_reg[j]);
            asum[j]  = amag[j][54:0] + cbse_pkg::WHALF;
            qprod[j] = y7_reg[j] * cbse_pkg::RECIP3;
            qv[j]    = 28'(qprod[j][61:33]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                a6_reg[j]   <= a_c[j];
                y7_reg[j]   <= asum[j][54:25];
                neg7_reg[j] <= a6_reg[j][55];
                w8_reg[j]   <= neg7_reg[j] ? -signed'(qv[j]) : signed'(qv[j]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 9 to 11: weighted sum per coordinate, magnitude and factor.
    // ------------------------------------------------------------------
    logic signed [59:0] pr9_reg  [4][3];
    logic signed [61:0] s10_reg  [3];
    logic [60:0]        m11_reg  [3];
    logic               neg11_reg[3];
    logic [47:0]        f11_reg;
    logic [47:0]        f_c;

    always_comb begin
        case (ctrl_reg[10].mode)
            cbse_pkg::MODE_VEL: f_c = {24'b0, inv_reg};
            cbse_pkg::MODE_ACC: f_c = inv_sq_reg;
            default:            f_c = 48'd1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                for (int j = 0; j < 4; j++) begin
                    pr9_reg[j][c] <= w8_reg[j] * pts_reg[8][j][c];
                end
                s10_reg[c] <= 62'(pr9_reg[0][c]) + 62'(pr9_reg[1][c])
                            + 62'(pr9_reg[2][c]) + 62'(pr9_reg[3][c]);
                m11_reg[c]   <= s10_reg[c][61] ? 61'(-s10_reg[c]) : 61'(s10_reg[c]);
                neg11_reg[c] <= s10_reg[c][61];
            end
            f11_reg <= f_c;
        end
    end

    // ------------------------------------------------------------------
    // Stages 12 to 14: magnitude times factor, in four partial products.
    // ------------------------------------------------------------------
    logic [54:0]  p00_reg [3], p01_reg [3];
    logic [53:0]  p10_reg [3], p11_reg [3];
    logic [78:0]  lo13_reg [3];
    logic [77:0]  hi13_reg [3];
    logic [108:0] pm14_reg [3];
    logic         neg12_reg [3], neg13_reg [3], neg14_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                p00_reg[c]   <= m11_reg[c][30:0]  * f11_reg[23:0];
                p01_reg[c]   <= m11_reg[c][30:0]  * f11_reg[47:24];
                p10_reg[c]   <= m11_reg[c][60:31] * f11_reg[23:0];
                p11_reg[c]   <= m11_reg[c][60:31] * f11_reg[47:24];
                neg12_reg[c] <= neg11_reg[c];
                lo13_reg[c]  <= 79'(p00_reg[c]) + {p01_reg[c], 24'b0};
                hi13_reg[c]  <= 78'(p10_reg[c]) + {p11_reg[c], 24'b0};
                neg13_reg[c] <= neg12_reg[c];
                pm14_reg[c]  <= 109'(lo13_reg[c]) + {hi13_reg[c], 31'b0};
                neg14_reg[c] <= neg13_reg[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 15: rounding shift, saturation, result register.
    // ------------------------------------------------------------------
    logic [109:0] rnd  [3];
    logic [85:0]  vmag [3];
    logic         sat  [3];
    logic [31:0]  oval [3];
    logic         any_sat;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (ctrl_reg[14].mode)
                cbse_pkg::MODE_VEL: begin
                    rnd[c]  = 110'(pm14_reg[c]) + (110'(1) << 39);
                    vmag[c] = 86'(rnd[c] >> 40);
                end
                cbse_pkg::MODE_ACC: begin
                    rnd[c]  = 110'(pm14_reg[c]) + (110'(1) << 55);
                    vmag[c] = 86'(rnd[c] >> 56);
                end
                default: begin
                    rnd[c]  = 110'(pm14_reg[c]) + (110'(1) << 23);
                    vmag[c] = 86'(rnd[c] >> 24);
                end
            endcase
            if (neg14_reg[c]) begin
                sat[c]  = (|vmag[c][85:32]) || (vmag[c][31] && (|vmag[c][30:0]));
                oval[c] = sat[c] ? 32'h8000_0000 : (32'd0 - vmag[c][31:0]);
            end else begin
                sat[c]  = |vmag[c][85:31];
                oval[c] = sat[c] ? 32'h7FFF_FFFF : vmag[c][31:0];
            end
        end
        any_sat = sat[0] || sat[1] || sat[2];
    end

    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic [1:0]         ost_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (ctrl_reg[14].query) begin
                ox_reg  <= signed'(oval[0]);
                oy_reg  <= signed'(oval[1]);
                oz_reg  <= signed'(oval[2]);
                ost_reg <= any_sat ? cbse_pkg::ST_SATURATED : cbse_pkg::ST_OK;
            end else begin
                ox_reg  <= '0;
                oy_reg  <= '0;
                oz_reg  <= '0;
                ost_reg <= ctrl_reg[14].status;
            end
        end
    end

    assign m_valid   = ctrl_reg[NST].valid;
    assign m_out_x   = ox_reg;
    assign m_out_y   = oy_reg;
    assign m_out_z   = oz_reg;
    assign m_segment = ctrl_reg[NST].seg;
    assign m_status  = ost_reg;

endmodule
